// ===== sv/icu_pkg.sv =====
// Shared constants, register codes and types for the codeword unranker.
`timescale 1ns / 1ps

package icu_pkg;

  localparam int MAX_POSITIONS = 8;
  localparam int MAX_LETTERS   = 16;

  localparam int RANK_W     = 32;
  localparam int WEIGHT_W   = 33;
  localparam int LETTER_W   = 4;
  localparam int POS_W      = 3;
  localparam int N_W        = 5;
  localparam int M_W        = 4;
  localparam int WIDX_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int QB_W       = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_LETTERS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISTINCT_LETTERS = 2'd2;

  localparam logic [N_W-1:0] RST_NUM_LETTERS      = 5'd6;
  localparam logic [M_W-1:0] RST_WORD_LENGTH      = 4'd4;
  localparam logic           RST_DISTINCT_LETTERS = 1'b0;

  // Effective configuration as seen by the sequencer.
  typedef struct packed {
    logic [N_W-1:0] n;
    logic [M_W-1:0] m;
    logic           distinct;
    logic           busy;
  } icu_cfg_t;

  typedef struct packed {
    logic load;
    logic start;
  } icu_div_ctl_t;

  typedef struct packed {
    logic init;
    logic take;
  } icu_let_ctl_t;

endpackage

// ===== sv/icu_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps

interface icu_cfg_if;
  import icu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/icu_in_if.sv =====
// Rank index input channel.
`timescale 1ns / 1ps

interface icu_in_if;
  import icu_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank_index;

  modport source (output valid, rank_index, input ready);
  modport sink   (input valid, rank_index, output ready);
endinterface

// ===== sv/icu_out_if.sv =====
// Letter result channel.
`timescale 1ns / 1ps

interface icu_out_if;
  import icu_pkg::*;

  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] letter;
  logic [POS_W-1:0]    position;
  logic                last_letter;
  logic                out_of_range;

  modport source (output valid, letter, position, last_letter, out_of_range, input ready);
  modport sink   (input valid, letter, position, last_letter, out_of_range, output ready);
endinterface

// ===== sv/icu_weights.sv =====
// Configuration registers and the iterative position weight calculator.
`timescale 1ns / 1ps

module icu_weights (
  input  logic                          clk,
  input  logic                          rst,
  icu_cfg_if.sink                       cfg,
  input  logic [icu_pkg::WIDX_W-1:0]    rd_idx,
  output logic [icu_pkg::WEIGHT_W-1:0]  rd_weight,
  output logic [icu_pkg::WEIGHT_W-1:0]  total,
  output icu_pkg::icu_cfg_t             st
);
  import icu_pkg::*;

  logic [N_W-1:0]      num_letters;
  logic [M_W-1:0]      word_length;
  logic                distinct;
  logic                pend;
  logic                running;
  logic [WIDX_W-1:0]   j;
  logic [WEIGHT_W-1:0] count;
  logic [WEIGHT_W-1:0] count_next;
  logic [WEIGHT_W-1:0] weights [0:MAX_POSITIONS];

  logic [N_W-1:0]          n_eff;
  logic [M_W-1:0]          m_eff;
  logic [N_W-1:0]          factor;
  logic [WEIGHT_W+N_W-1:0] prod;
  logic                    cfg_hit;
  logic                    step_en;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (num_letters > N_W'(MAX_LETTERS)) n_eff = N_W'(MAX_LETTERS);
    else n_eff = num_letters;
    if (word_length == '0) m_eff = M_W'(1);
    else if (word_length > M_W'(MAX_POSITIONS)) m_eff = M_W'(MAX_POSITIONS);
    else m_eff = word_length;
  end

  // In distinct mode, position j has n - j + 1 letters left to choose from.
  always_comb begin
    if (distinct) begin
      if (N_W'(j) <= n_eff) factor = n_eff - N_W'(j) + N_W'(1);
      else factor = '0;
    end else begin
      factor = n_eff;
    end
    prod = (WEIGHT_W+N_W)'(count) * (WEIGHT_W+N_W)'(factor);
    if (prod > (WEIGHT_W+N_W)'(WEIGHT_MAX)) count_next = WEIGHT_MAX;
    else count_next = prod[WEIGHT_W-1:0];
  end

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg.valid && cfg.ready) begin
      cfg_hit = (cfg.index == REG_NUM_LETTERS) || (cfg.index == REG_WORD_LENGTH) ||
                (cfg.index == REG_DISTINCT_LETTERS);
    end
  end

  assign step_en = running && !pend && !cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_letters   <= RST_NUM_LETTERS;
      word_length   <= RST_WORD_LENGTH;
      distinct      <= RST_DISTINCT_LETTERS;
      pend          <= 1'b1;
      running       <= 1'b0;
      j             <= '0;
      count         <= '0;
    end else begin
      if (cfg_hit) begin
        unique case (cfg.index)
          REG_NUM_LETTERS:      num_letters   <= cfg.data[N_W-1:0];
          REG_WORD_LENGTH:      word_length   <= cfg.data[M_W-1:0];
          REG_DISTINCT_LETTERS: distinct      <= cfg.data[0];
          default: ;
        endcase
        pend    <= 1'b1;
        running <= 1'b0;
      end else if (pend) begin
        pend    <= 1'b0;
        running <= 1'b1;
        j       <= WIDX_W'(m_eff);
        count   <= WEIGHT_W'(1);
      end else if (running) begin
        if (j != '0) begin
          count <= count_next;
          j     <= j - WIDX_W'(1);
        end else begin
          running <= 1'b0;
        end
      end
    end
  end

  // Weight j is written on the way down; the population size lands in entry 0.
  always_ff @(posedge clk) begin
    if (step_en) begin
      weights[j] <= count;
    end
  end

  assign rd_weight   = weights[rd_idx];
  assign total       = weights[0];
  assign st.n        = n_eff;
  assign st.m        = m_eff;
  assign st.distinct = distinct;
  assign st.busy     = pend || running;

endmodule

// ===== sv/icu_divider.sv =====
// Shared restoring divider: one quotient bit per cycle against a latched weight.
`timescale 1ns / 1ps

module icu_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  icu_pkg::icu_div_ctl_t         ctl,
  input  logic [icu_pkg::RANK_W-1:0]    rank,
  input  logic [icu_pkg::WEIGHT_W-1:0]  weight,
  output logic                          busy,
  output logic [icu_pkg::LETTER_W-1:0]  digit
);
  import icu_pkg::*;

  localparam int TRIAL_W = WEIGHT_W + LETTER_W;

  logic [RANK_W-1:0]   rem;
  logic [WEIGHT_W-1:0] wreg;
  logic [LETTER_W-1:0] q;
  logic [QB_W-1:0]     bitc;
  logic [TRIAL_W-1:0]  trial;
  logic                fits;

  assign trial = TRIAL_W'(wreg) << bitc;
  assign fits  = TRIAL_W'(rem) >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy && bitc == '0) begin
      busy <= 1'b0;
    end
  end

  // The remainder carries over from one position to the next.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= rank;
    end
    if (ctl.start) begin
      wreg <= weight;
      q    <= '0;
      bitc <= QB_W'(LETTER_W - 1);
    end else if (busy) begin
      if (fits) begin
        rem     <= rem - trial[RANK_W-1:0];
        q[bitc] <= 1'b1;
      end
      bitc <= bitc - QB_W'(1);
    end
  end

  assign digit = (wreg == '0) ? '0 : q;

endmodule

// ===== sv/icu_letters.sv =====
// Ordered list of unused letters with removal at the selected digit.
`timescale 1ns / 1ps

module icu_letters (
  input  logic                          clk,
  input  icu_pkg::icu_let_ctl_t         ctl,
  input  logic [icu_pkg::N_W-1:0]       n,
  input  logic                          distinct,
  input  logic [icu_pkg::LETTER_W-1:0]  digit,
  output logic [icu_pkg::LETTER_W-1:0]  letter
);
  import icu_pkg::*;

  logic [LETTER_W-1:0] avail [MAX_LETTERS];
  logic [N_W-1:0]      remaining;
  logic [LETTER_W-1:0] sel;

  always_comb begin
    if (N_W'(digit) >= remaining) sel = LETTER_W'(remaining - N_W'(1));
    else sel = digit;
    if (!distinct) letter = digit;
    else if (remaining == '0) letter = '0;
    else letter = avail[sel];
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int k = 0; k < MAX_LETTERS; k++) begin
        avail[k] <= LETTER_W'(k);
      end
      remaining <= n;
    end else if (ctl.take && distinct && remaining != '0) begin
      for (int k = 0; k < MAX_LETTERS - 1; k++) begin
        if (k >= int'(sel)) avail[k] <= avail[k+1];
      end
      remaining <= remaining - N_W'(1);
    end
  end

endmodule

// ===== sv/index_to_codeword_unrank_core.sv =====
// Codeword unranker top level: sequencer, output register and unit wiring.
// After a rank transfer, each letter takes a weight latch, the divider steps, a finish
// step and emit; the divider gives one quotient bit per cycle. An out-of-range rank goes
// straight to a single flagged result. One item is in work at a time.
// A config write or reset recomputes the weights, rank ready low meanwhile.
// Reset is synchronous: registers return to n=6, m=4, repeats allowed, outputs empty.
`timescale 1ns / 1ps

module index_to_codeword_unrank_core (
  input  logic       clk,
  input  logic       rst,
  icu_cfg_if.sink    cfg,
  icu_in_if.sink     ranks,
  icu_out_if.source  letters
);
  import icu_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_START, S_DIV, S_EMIT, S_OOR} state_t;

  state_t              state;
  logic [POS_W-1:0]    pos;
  logic                ovalid;
  logic [LETTER_W-1:0] o_letter;
  logic [POS_W-1:0]    o_pos;
  logic                o_last;
  logic                o_oor;

  icu_cfg_t            wst;
  icu_div_ctl_t        div_ctl;
  icu_let_ctl_t        let_ctl;
  logic [WIDX_W-1:0]   rd_idx;
  logic [WEIGHT_W-1:0] rd_weight;
  logic [WEIGHT_W-1:0] total;
  logic                div_busy;
  logic [LETTER_W-1:0] digit;
  logic [LETTER_W-1:0] letter;
  logic                take_in;
  logic                slot;
  logic                emit;
  logic                last;

  icu_weights u_weights (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rd_idx    (rd_idx),
    .rd_weight (rd_weight),
    .total     (total),
    .st        (wst)
  );

  icu_divider u_divider (
    .clk    (clk),
    .rst    (rst),
    .ctl    (div_ctl),
    .rank   (ranks.rank_index),
    .weight (rd_weight),
    .busy   (div_busy),
    .digit  (digit)
  );

  icu_letters u_letters (
    .clk      (clk),
    .ctl      (let_ctl),
    .n        (wst.n),
    .distinct (wst.distinct),
    .digit    (digit),
    .letter   (letter)
  );

  assign ranks.ready   = (state == S_IDLE) && !wst.busy;
  assign take_in       = ranks.valid && ranks.ready;
  assign slot          = !ovalid || letters.ready;
  assign emit          = ((state == S_EMIT) || (state == S_OOR)) && slot;
  assign div_ctl.load  = take_in;
  assign div_ctl.start = (state == S_START);
  assign let_ctl.init  = take_in;
  assign let_ctl.take  = (state == S_EMIT) && slot;
  assign rd_idx        = WIDX_W'(pos) + WIDX_W'(1);
  assign last          = (M_W'(pos) == wst.m - M_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      pos    <= '0;
    end else begin
      if (letters.ready && !emit) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take_in) begin
            pos <= '0;
            if (WEIGHT_W'(ranks.rank_index) >= total) state <= S_OOR;
            else state <= S_START;
          end
        end
        S_START: state <= S_DIV;
        S_DIV: begin
          if (!div_busy) state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot) begin
            ovalid   <= 1'b1;
            o_letter <= letter;
            o_pos    <= pos;
            o_last   <= last;
            o_oor    <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              pos   <= pos + POS_W'(1);
              state <= S_START;
            end
          end
        end
        S_OOR: begin
          if (slot) begin
            ovalid   <= 1'b1;
            o_letter <= '0;
            o_pos    <= '0;
            o_last   <= 1'b1;
            o_oor    <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign letters.valid        = ovalid;
  assign letters.letter       = o_letter;
  assign letters.position     = o_pos;
  assign letters.last_letter  = o_last;
  assign letters.out_of_range = o_oor;

endmodule
